/* design/pps_pkg.sv */
// Shared types, codes and constants for the projector power supervisor.
// Depends on nothing; every design file refers to it by scoped names.

package pps_pkg;

   // Width of the saturating millisecond counters.
   localparam int TimerWidth = 18;
   // Width of the timing configuration registers.
   localparam int CfgWidth = 17;
   // Common width used when a counter is compared against a register.
   localparam int CmpWidth = (TimerWidth > CfgWidth) ? TimerWidth : CfgWidth;

   // Configuration port geometry.
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = CfgWidth;

   // Widths of the stream payloads; both tdata widths are byte-padded.
   localparam int ReqDataWidth = 8;
   localparam int ReqUserWidth = 2;
   localparam int RspDataWidth = 16;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_WARMUP_DELAY = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TURN_ON_TIMEOUT = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_COOLING_TIMEOUT = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MIRRORED = 2'd3;

   // Configuration reset values.
   localparam logic [CfgWidth-1:0] WarmupDelayReset = 17'd15000;
   localparam logic [CfgWidth-1:0] TurnOnTimeoutReset = 17'd45000;
   localparam logic [CfgWidth-1:0] CoolingTimeoutReset = 17'd30000;

   // Item kinds carried on the request side.
   typedef logic [1:0] op_type;
   localparam op_type OP_HOST = 2'd0;
   localparam op_type OP_REPORT = 2'd1;
   localparam op_type OP_TICK = 2'd2;

   typedef enum logic [2:0] {
      ST_UNKNOWN = 3'd0,
      ST_OFF = 3'd1,
      ST_TURNING_ON = 3'd2,
      ST_WARMING = 3'd3,
      ST_ON = 3'd4,
      ST_COOLING = 3'd5,
      ST_TIMEOUT = 3'd6,
      ST_FAIL = 3'd7
   } lamp_status_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_OFF = 2'd1,
      CMD_ON = 2'd2
   } power_cmd_type;

   typedef enum logic [1:0] {
      ORIENT_NONE = 2'd0,
      ORIENT_NORMAL = 2'd1,
      ORIENT_MIRRORED = 2'd2
   } orient_cmd_type;

   typedef struct packed {
      logic [CfgWidth-1:0] warmup_delay_ms;
      logic [CfgWidth-1:0] turn_on_timeout_ms;
      logic [CfgWidth-1:0] cooling_timeout_ms;
      logic                mirrored;
   } cfg_type;

   typedef struct packed {
      op_type op;
      logic   level;
   } req_type;

   // Packed with the last result field in the lowest bits.
   typedef struct packed {
      logic            status_changed;
      logic            fail_event;
      lamp_status_type lamp_status;
      orient_cmd_type  orientation_command;
      power_cmd_type   power_command;
   } rsp_type;

   localparam int RspWidth = $bits(rsp_type);

endpackage

/* design/pps_csr.sv */
// Configuration registers of the projector power supervisor.
// Depends on pps_pkg for the register indexes, widths and reset values.

module pps_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pps_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [pps_pkg::CsrDataWidth-1:0]  csr_wdata,
   output pps_pkg::cfg_type                  cfg
);

   pps_pkg::cfg_type cfg_ff;
   pps_pkg::cfg_type cfg_in;

   // Decode a write into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pps_pkg::CSR_WARMUP_DELAY: begin
               cfg_in.warmup_delay_ms = csr_wdata[pps_pkg::CfgWidth-1:0];
            end
            pps_pkg::CSR_TURN_ON_TIMEOUT: begin
               cfg_in.turn_on_timeout_ms = csr_wdata[pps_pkg::CfgWidth-1:0];
            end
            pps_pkg::CSR_COOLING_TIMEOUT: begin
               cfg_in.cooling_timeout_ms = csr_wdata[pps_pkg::CfgWidth-1:0];
            end
            pps_pkg::CSR_MIRRORED: begin
               cfg_in.mirrored = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warmup_delay_ms <= pps_pkg::WarmupDelayReset;
         cfg_ff.turn_on_timeout_ms <= pps_pkg::TurnOnTimeoutReset;
         cfg_ff.cooling_timeout_ms <= pps_pkg::CoolingTimeoutReset;
         cfg_ff.mirrored <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/pps_fsm.sv */
// Lamp status state machine with its commanded flag and millisecond counters.
// Depends on pps_pkg for the status, command and item types.

module pps_fsm (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  pps_pkg::req_type  item,
   input  pps_pkg::cfg_type  cfg,
   output pps_pkg::rsp_type  result
);

   localparam logic [pps_pkg::TimerWidth-1:0] TimerMax = '1;

   pps_pkg::lamp_status_type lamp_ff;
   pps_pkg::lamp_status_type lamp_in;
   logic commanded_on_ff;
   logic commanded_on_in;
   logic [pps_pkg::TimerWidth-1:0] since_cmd_ff;
   logic [pps_pkg::TimerWidth-1:0] since_cmd_in;
   logic [pps_pkg::TimerWidth-1:0] since_warm_ff;
   logic [pps_pkg::TimerWidth-1:0] since_warm_in;

   logic send_cmd;
   logic send_on;
   logic turn_on_expired;
   logic warmup_done;
   logic cooling_expired;

   // Timer checks: elapsed time strictly above the configured limit.
   assign turn_on_expired = pps_pkg::CmpWidth'(since_cmd_ff)
                            > pps_pkg::CmpWidth'(cfg.turn_on_timeout_ms);
   assign warmup_done = pps_pkg::CmpWidth'(since_warm_ff)
                        > pps_pkg::CmpWidth'(cfg.warmup_delay_ms);
   assign cooling_expired = pps_pkg::CmpWidth'(since_cmd_ff)
                            > pps_pkg::CmpWidth'(cfg.cooling_timeout_ms);

   // Next state and result for the item at the head of the pipeline.
   always_comb begin
      lamp_in = lamp_ff;
      commanded_on_in = commanded_on_ff;
      since_cmd_in = since_cmd_ff;
      since_warm_in = since_warm_ff;
      send_cmd = 1'b0;
      send_on = 1'b0;
      result.power_command = pps_pkg::CMD_NONE;
      result.orientation_command = pps_pkg::ORIENT_NONE;
      result.fail_event = 1'b0;
      result.status_changed = 1'b0;

      case (item.op)
         pps_pkg::OP_HOST: begin
            commanded_on_in = item.level;
            send_cmd = 1'b1;
            send_on = item.level;
         end
         pps_pkg::OP_REPORT: begin
            if (commanded_on_ff && !item.level) begin
               // Lamp should be on but the projector says off.
               if (lamp_ff inside {pps_pkg::ST_OFF, pps_pkg::ST_UNKNOWN,
                                   pps_pkg::ST_TIMEOUT, pps_pkg::ST_FAIL}) begin
                  send_cmd = 1'b1;
                  send_on = 1'b1;
               end else if (lamp_ff == pps_pkg::ST_TURNING_ON) begin
                  if (turn_on_expired) begin
                     lamp_in = pps_pkg::ST_TIMEOUT;
                     result.status_changed = 1'b1;
                     result.fail_event = 1'b1;
                     commanded_on_in = 1'b0;
                  end
               end else if (lamp_ff inside {pps_pkg::ST_WARMING, pps_pkg::ST_ON}) begin
                  lamp_in = pps_pkg::ST_FAIL;
                  result.status_changed = 1'b1;
                  result.fail_event = 1'b1;
                  commanded_on_in = 1'b0;
               end else begin
                  lamp_in = pps_pkg::ST_OFF;
                  result.status_changed = 1'b1;
               end
            end else if (commanded_on_ff) begin
               // Lamp should be on and the projector agrees.
               if (lamp_ff == pps_pkg::ST_TURNING_ON) begin
                  lamp_in = pps_pkg::ST_WARMING;
                  result.status_changed = 1'b1;
                  since_warm_in = '0;
               end else if (lamp_ff == pps_pkg::ST_WARMING) begin
                  if (warmup_done) begin
                     lamp_in = pps_pkg::ST_ON;
                     result.status_changed = 1'b1;
                  end
               end else if (lamp_ff != pps_pkg::ST_ON) begin
                  lamp_in = pps_pkg::ST_ON;
                  result.status_changed = 1'b1;
               end
            end else if (!item.level) begin
               // Lamp should be off and it is.
               if (lamp_ff != pps_pkg::ST_OFF) begin
                  lamp_in = pps_pkg::ST_OFF;
                  result.status_changed = 1'b1;
               end
            end else begin
               // Lamp should be off but the projector says on.
               if (lamp_ff == pps_pkg::ST_COOLING) begin
                  if (cooling_expired) begin
                     lamp_in = pps_pkg::ST_ON;
                     result.status_changed = 1'b1;
                  end
               end else if (lamp_ff == pps_pkg::ST_OFF) begin
                  // Switched on by hand: adopt it as a commanded power on.
                  commanded_on_in = 1'b1;
                  send_cmd = 1'b1;
                  send_on = 1'b1;
               end else begin
                  send_cmd = 1'b1;
                  send_on = 1'b0;
               end
            end
         end
         pps_pkg::OP_TICK: begin
            if (since_cmd_ff != TimerMax) begin
               since_cmd_in = since_cmd_ff + 1'b1;
            end
            if (since_warm_ff != TimerMax) begin
               since_warm_in = since_warm_ff + 1'b1;
            end
         end
         default: begin
            lamp_in = lamp_ff;
         end
      endcase

      // Issue a power command and restart the command timer.
      if (send_cmd) begin
         if (send_on) begin
            result.power_command = pps_pkg::CMD_ON;
            result.orientation_command = cfg.mirrored ? pps_pkg::ORIENT_MIRRORED
                                                      : pps_pkg::ORIENT_NORMAL;
            lamp_in = pps_pkg::ST_TURNING_ON;
         end else begin
            result.power_command = pps_pkg::CMD_OFF;
            lamp_in = pps_pkg::ST_COOLING;
         end
         since_cmd_in = '0;
         result.status_changed = 1'b1;
      end

      result.lamp_status = lamp_in;
   end

   // State registers advance only when an item is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_ff <= pps_pkg::ST_UNKNOWN;
         commanded_on_ff <= 1'b0;
         since_cmd_ff <= '0;
         since_warm_ff <= '0;
      end else if (step) begin
         lamp_ff <= lamp_in;
         commanded_on_ff <= commanded_on_in;
         since_cmd_ff <= since_cmd_in;
         since_warm_ff <= since_warm_in;
      end
   end

endmodule

/* design/projector_power_supervisor.sv */
// Top level of the projector power supervisor: input register, status logic,
// result register. Depends on pps_pkg, pps_csr and pps_fsm.
//
//   Port group  Direction  Moves
//   req_*       in         one item: kind (op) in tuser, level in tdata
//   rsp_*       out        one result item per accepted item
//   csr_*       in         register writes, no read-back
//
// One item per clock cycle sustained while rsp_tready stays high; each result is
// presented on rsp_* from the result register, which loads the status logic's
// output while the item is held in the input register.
// Synchronous reset clears the lamp status to unknown, both counters and the
// commanded flag, and restores register defaults. While rsp_tready is low, items
// fill the result and input registers and then req_tready drops.

module projector_power_supervisor (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pps_pkg::ReqDataWidth-1:0]  req_tdata,  // [0] level
   input  logic [pps_pkg::ReqUserWidth-1:0]  req_tuser,  // [1:0] op
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] power_command, [3:2] orientation_command, [6:4] lamp_status,
   // [7] fail_event, [8] status_changed
   output logic [pps_pkg::RspDataWidth-1:0]  rsp_tdata,
   // Configuration port.
   input  logic                              csr_we,
   input  logic [pps_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [pps_pkg::CsrDataWidth-1:0]  csr_wdata
);

   pps_pkg::cfg_type cfg;
   pps_pkg::rsp_type result;

   logic             in_valid_ff;
   logic             in_valid_in;
   pps_pkg::req_type in_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   pps_pkg::rsp_type rsp_ff;
   logic             step;

   pps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pps_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_ff),
      .cfg    (cfg),
      .result (result)
   );

   // The held item moves on when the result register is free or draining.
   assign step = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.op <= req_tuser;
         in_ff.level <= req_tdata[0];
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(pps_pkg::RspDataWidth - pps_pkg::RspWidth){1'b0}}, rsp_ff};

`ifndef ASSERT_OFF
   // An orientation command only goes out together with power on.
   a_orient_with_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.orientation_command != pps_pkg::ORIENT_NONE)
      |-> (rsp_ff.power_command == pps_pkg::CMD_ON))
      else $error("orientation command without power on");

   // A failure leaves the lamp in timeout or fail.
   a_fail_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.fail_event
      |-> (rsp_ff.lamp_status == pps_pkg::ST_TIMEOUT)
          || (rsp_ff.lamp_status == pps_pkg::ST_FAIL))
      else $error("failure reported with wrong lamp status");

   // A command sent implies the change flag.
   a_cmd_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.power_command != pps_pkg::CMD_NONE)
      |-> rsp_ff.status_changed)
      else $error("power command without change flag");

   // Each processed item produces a result in the next cycle.
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed item produced no result");
`endif

endmodule
